>>> rtl/dcdf_pkg.sv
// Shared types and constants for the dilated causal depthwise FIR unit.
// No dependencies.
`default_nettype none
package dcdf_pkg;
	localparam int Taps = 7;
	localparam int Channels = 64;
	localparam int MaxSpacing = 16;
	localparam int Hist = (Taps - 1) * MaxSpacing;
	localparam int ChW = 6;
	localparam int SlotW = 7;
	localparam int TapW = 3;
	localparam int HAddrW = 13;
	localparam int WAddrW = 9;
	localparam int AccW = 48;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_WEIGHT = 2'd1;
	localparam logic [1:0] KIND_BIAS = 2'd2;

	typedef struct packed {
		logic init;
		logic [WAddrW-1:0] addr;
		logic load;
		logic wr_weight;
		logic wr_bias;
		logic clr;
		logic mac;
		logic tap_used;
		logic [TapW-1:0] tap;
		logic finish;
	} dcdf_cmd_t;

	typedef struct packed {
		logic out_full;
		logic out_taken;
	} dcdf_sts_t;
endpackage
`default_nettype wire

>>> rtl/dilated_causal_depthwise_fir_unit.sv
// Dilated causal depthwise FIR, top level: controller plus datapath.
// A sample word is taken in S_IDLE with its pointer and bias read; then S_RD,
// seven tap reads through one history port in S_MAC, the MAC drain and S_FIN,
// which may stall on the output; no word is taken until S_IDLE.
// Reset: asynchronous; then a clearing pass, with s_tready low, zeroes
// weights, bias, pointers and counts; history reads are gated by the sample count.
`default_nettype none
module dilated_causal_depthwise_fir_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [4:0] cfg_wdata,
	input wire logic s_tvalid,
	output logic s_tready,
	// kind[1:0], chan[7:2], tap_index[10:8], sample_value[34:11], coeff_value[52:35]
	input wire logic [55:0] s_tdata,
	// restart
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// out_chan[5:0], filtered[29:6]
	output logic [31:0] m_tdata,
	// clipped
	output logic m_tuser
);
	import dcdf_pkg::*;
	logic [4:0] spacing_q;
	dcdf_cmd_t cmd;
	dcdf_sts_t sts;
	logic [5:0] oc;
	logic signed [23:0] ov;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			spacing_q <= 5'd1;
		else if (cfg_we)
			spacing_q <= cfg_wdata;
	end

	dcdf_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_kind(s_tdata[1:0]), .in_chan(s_tdata[7:2]), .in_tap(s_tdata[10:8]),
		.cmd, .sts
	);

	dcdf_datapath u_dp (
		.clk, .arst_n, .cmd, .sts,
		.spacing(spacing_q),
		.in_chan(s_tdata[7:2]), .in_tap(s_tdata[10:8]),
		.in_x(s_tdata[34:11]), .in_w(s_tdata[52:35]), .in_restart(s_tuser),
		.out_chan(oc), .out_val(ov), .out_clip(m_tuser),
		.out_valid(m_tvalid), .out_ready(m_tready)
	);

	assign m_tdata = {2'b00, ov, oc};
endmodule
`default_nettype wire

>>> rtl/dcdf_datapath.sv
// Datapath: coefficient, history and pointer stores, one shared MAC, output register.
// Uses dcdf_pkg.
`default_nettype none
module dcdf_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire dcdf_pkg::dcdf_cmd_t cmd,
	output dcdf_pkg::dcdf_sts_t sts,
	input wire logic [4:0] spacing,
	input wire logic [5:0] in_chan,
	input wire logic [2:0] in_tap,
	input wire logic signed [23:0] in_x,
	input wire logic signed [17:0] in_w,
	input wire logic in_restart,
	output logic [5:0] out_chan,
	output logic signed [23:0] out_val,
	output logic out_clip,
	output logic out_valid,
	input wire logic out_ready
);
	import dcdf_pkg::*;
	logic [ChW-1:0] ch_q;
	logic [2:0] tapi_q;
	logic signed [23:0] x_q;
	logic signed [17:0] w_q;
	logic rst_q;
	logic [SlotW-1:0] slot_q, seen_q;
	logic [SlotW-1:0] wslot_rd_q, seen_rd_q;
	logic signed [23:0] bias_rd_q;
	logic [4:0] d_q;
	logic signed [23:0] hist_mem [Channels*Hist];
	logic signed [17:0] wt_mem [Channels*Taps];
	logic signed [23:0] bias_mem [Channels];
	logic [SlotW-1:0] wslot_mem [Channels];
	logic [SlotW-1:0] seen_mem [Channels];
	logic signed [23:0] hrd_q;
	logic signed [17:0] wrd_q;
	logic use_q, mac_s1;
	logic signed [AccW-1:0] acc_q;
	logic full_q;
	logic [SlotW-1:0] lag;
	logic [SlotW:0] pos;
	logic [WAddrW-1:0] waddr;
	logic signed [AccW-1:0] rnd;
	logic signed [AccW-17:0] q;

	assign lag = SlotW'((Taps - 1 - int'(cmd.tap)) * int'(d_q));
	always_comb begin
		pos = {1'b0, slot_q} + (SlotW+1)'(Hist) - {1'b0, lag};
		if (pos >= (SlotW+1)'(Hist))
			pos = pos - (SlotW+1)'(Hist);
	end
	assign waddr = WAddrW'(int'(ch_q) * Taps + int'(cmd.tap));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			mac_s1 <= 1'b0;
		end else begin
			mac_s1 <= cmd.mac;
			if (cmd.finish)
				full_q <= 1'b1;
			else if (out_valid && out_ready)
				full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q <= in_chan;
			tapi_q <= in_tap;
			x_q <= in_x;
			w_q <= in_w;
			rst_q <= in_restart;
			wslot_rd_q <= wslot_mem[in_chan];
			seen_rd_q <= seen_mem[in_chan];
			bias_rd_q <= bias_mem[in_chan];
			d_q <= (spacing == 5'd0) ? 5'd1 :
				(spacing > 5'(MaxSpacing)) ? 5'(MaxSpacing) : spacing;
		end
		if (cmd.init)
			wt_mem[cmd.addr] <= '0;
		else if (cmd.wr_weight)
			wt_mem[WAddrW'(int'(ch_q) * Taps + int'(tapi_q))] <= w_q;
		if (cmd.init) begin
			if (cmd.addr < WAddrW'(Channels)) begin
				bias_mem[cmd.addr[ChW-1:0]] <= '0;
				wslot_mem[cmd.addr[ChW-1:0]] <= '0;
				seen_mem[cmd.addr[ChW-1:0]] <= '0;
			end
		end else begin
			if (cmd.wr_bias)
				bias_mem[ch_q] <= x_q;
			if (cmd.finish) begin
				wslot_mem[ch_q] <= (slot_q == SlotW'(Hist - 1)) ? '0 : slot_q + 1'b1;
				if (seen_q < SlotW'(Hist))
					seen_mem[ch_q] <= seen_q + 1'b1;
			end
		end
		if (cmd.clr) begin
			slot_q <= rst_q ? '0 : wslot_rd_q;
			seen_q <= rst_q ? '0 : seen_rd_q;
		end
		if (cmd.mac) begin
			hrd_q <= (lag == '0) ? x_q :
				hist_mem[HAddrW'(int'(ch_q) * Hist + int'(pos))];
			wrd_q <= wt_mem[waddr];
			use_q <= cmd.tap_used && (lag == '0 || lag <= seen_q);
		end
		if (cmd.clr)
			acc_q <= AccW'(bias_rd_q) <<< 16;
		else if (mac_s1 && use_q)
			acc_q <= acc_q + AccW'(hrd_q * wrd_q);
		if (cmd.finish) begin
			hist_mem[HAddrW'(int'(ch_q) * Hist + int'(slot_q))] <= x_q;
			out_chan <= ch_q;
			if (q > 32'sd8388607) begin
				out_val <= 24'sh7FFFFF;
				out_clip <= 1'b1;
			end else if (q < -32'sd8388608) begin
				out_val <= 24'sh800000;
				out_clip <= 1'b1;
			end else begin
				out_val <= q[23:0];
				out_clip <= 1'b0;
			end
		end
	end

	assign rnd = acc_q + AccW'(32768);
	assign q = rnd[AccW-1:16];
	assign out_valid = full_q;
	assign sts.out_full = full_q;
	assign sts.out_taken = full_q && out_ready;
endmodule
`default_nettype wire

>>> rtl/dcdf_ctrl.sv
// Controller: sequences the clearing pass, load, seven tap reads, MAC drain and result.
// Uses dcdf_pkg.
`default_nettype none
module dcdf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] in_kind,
	input wire logic [5:0] in_chan,
	input wire logic [2:0] in_tap,
	output dcdf_pkg::dcdf_cmd_t cmd,
	input wire dcdf_pkg::dcdf_sts_t sts
);
	import dcdf_pkg::*;
	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_WLD, S_BLD, S_RD, S_MAC, S_DRAIN, S_FIN
	} state_t;
	state_t state_q;
	logic [TapW-1:0] tap_q;
	logic [WAddrW-1:0] addr_q;
	logic take;

	assign in_ready = (state_q == S_IDLE);
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			tap_q <= '0;
			addr_q <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == WAddrW'(Channels * Taps - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					tap_q <= '0;
					if (take && int'(in_chan) < Channels) begin
						if (in_kind == KIND_WEIGHT && int'(in_tap) < Taps)
							state_q <= S_WLD;
						else if (in_kind == KIND_BIAS)
							state_q <= S_BLD;
						else if (in_kind == KIND_SAMPLE)
							state_q <= S_RD;
					end
				end
				S_WLD, S_BLD: state_q <= S_IDLE;
				S_RD: state_q <= S_MAC;
				S_MAC: begin
					tap_q <= tap_q + 1'b1;
					if (tap_q == TapW'(Taps - 1))
						state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_FIN;
				S_FIN: if (!sts.out_full || sts.out_taken)
					state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.init = (state_q == S_INIT);
		cmd.addr = addr_q;
		cmd.load = take;
		cmd.wr_weight = (state_q == S_WLD);
		cmd.wr_bias = (state_q == S_BLD);
		cmd.clr = (state_q == S_RD);
		cmd.mac = (state_q == S_MAC);
		cmd.tap_used = 1'b1;
		cmd.tap = tap_q;
		cmd.finish = (state_q == S_FIN) && (!sts.out_full || sts.out_taken);
	end

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mac && cmd.finish)) else $error("mac during finish");
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac |-> int'(tap_q) < Taps) else $error("tap out of range");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |=> state_q == S_FIN) else $error("drain skipped");
endmodule
`default_nettype wire
